>>> src/spimw_pkg.sv
package spimw_pkg;

  // Command codes carried by an input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_SPI_MODE = 1'b0;
  localparam logic REG_CLK_DIV  = 1'b1;

  // Slot counter width: covers write_count + read_count
  localparam int unsigned SLOT_W = 9;

  typedef struct packed {
    logic [1:0] cmd;
    logic       miso;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic [4:0] write_count;
    logic [7:0] read_count;
    logic [4:0] overlap_count;
  } in_t;

  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       busy_res;
    logic       done_res;
    logic       start_error;
  } out_t;

endpackage

>>> src/spimw_wbuf.sv
module spimw_wbuf #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [7:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [7:0]                          rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, a same-cycle write to the read address is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/spi_master_write_read_transaction_unit.sv
// SPI master, 8-bit MSB-first frames, write/read transaction with overlap.
// Latency: one item in, its result registered and shown the next cycle.
// Throughput: one item per cycle while results are taken; a byte slot takes
// 16 * 2^div tick items (div: clock divider register), one bit per SCLK period.
// Reset (rst_ni low, async): idle, chip select high, registers zero; the
// write buffer holds nothing defined until loaded.
module spi_master_write_read_transaction_unit #(
  parameter int unsigned WRITE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spimw_pkg::in_t    in_data_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spimw_pkg::out_t   out_data_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import spimw_pkg::*;

  localparam int unsigned AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] DEPTH_W = SLOT_W'(WRITE_DEPTH);

  // Control and shift state
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] total_q, total_d;
  logic [4:0]        cap_q, cap_d;
  logic [4:0]        wlen_q, wlen_d;
  logic [2:0]        bit_q, bit_d;
  logic [6:0]        div_q, div_d;
  logic              lvl_q, lvl_d;
  logic              phase_q, phase_d;
  logic [7:0]        tx_q, tx_d;
  logic [7:0]        rx_q, rx_d;
  logic              active_q, active_d;
  logic [1:0]        mode_q;
  logic [2:0]        baud_q;

  out_t              res_q, res_d;
  logic              out_valid_q;

  logic              accept;
  logic              cfg_we;
  logic              buf_we;
  logic [7:0]        buf_rd;
  logic [AW-1:0]     buf_waddr;
  logic [AW-1:0]     buf_raddr;

  logic              cpol;
  logic              cpha;
  logic [7:0]        half;
  logic [7:0]        div_inc;
  logic [7:0]        rx_new;
  logic [SLOT_W-1:0] slot_nx;
  logic [SLOT_W-1:0] start_total;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = res_q;

  assign cpol = mode_q[1];
  assign cpha = mode_q[0];

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !active_q;

  always_comb begin
    unique case (paddr[2])
      REG_SPI_MODE: prdata = {30'd0, mode_q};
      REG_CLK_DIV:  prdata = {29'd0, baud_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      baud_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SPI_MODE: mode_q <= pwdata[1:0];
        REG_CLK_DIV:  baud_q <= pwdata[2:0];
        default:      ;
      endcase
    end
  end

  // Write buffer, prefetches the byte for the next slot
  spimw_wbuf #(
    .DEPTH (WRITE_DEPTH)
  ) u_wbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (in_data_i.load_byte),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rd)
  );

  assign buf_waddr = AW'({{(SLOT_W-4){1'b0}}, in_data_i.load_index});
  assign buf_raddr = active_d ? AW'(slot_d + SLOT_W'(1)) : '0;

  assign half        = 8'd1 << baud_q;
  assign div_inc     = {1'b0, div_q} + 8'd1;
  assign slot_nx     = slot_q + SLOT_W'(1);
  assign start_total = SLOT_W'(in_data_i.write_count) + SLOT_W'(in_data_i.read_count)
                     - SLOT_W'(in_data_i.overlap_count);

  // One item: tick, load or start
  always_comb begin
    slot_d   = slot_q;
    total_d  = total_q;
    cap_d    = cap_q;
    wlen_d   = wlen_q;
    bit_d    = bit_q;
    div_d    = div_q;
    lvl_d    = lvl_q;
    phase_d  = phase_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    active_d = active_q;
    buf_we   = 1'b0;
    res_d    = '0;
    rx_new   = {rx_q[6:0], in_data_i.miso};

    if (accept) begin
      unique case (in_data_i.cmd)
        CMD_TICK: begin
          if (active_q) begin
            if (div_inc < half) begin
              div_d = div_inc[6:0];
            end else begin
              div_d = '0;
              if (!phase_q) begin
                // leading edge
                lvl_d   = ~cpol;
                phase_d = 1'b1;
                if (!cpha) begin
                  rx_d = rx_new;
                end else if (bit_q != 3'd0) begin
                  tx_d = {tx_q[6:0], 1'b0};
                end
              end else begin
                // trailing edge
                lvl_d   = cpol;
                phase_d = 1'b0;
                if (!cpha) begin
                  tx_d = {tx_q[6:0], 1'b0};
                end else begin
                  rx_d = rx_new;
                end
                bit_d = bit_q + 3'd1;
                if (bit_q == 3'd7) begin
                  // slot complete
                  if (slot_q >= SLOT_W'(cap_q)) begin
                    res_d.rx_valid = 1'b1;
                    res_d.rx_byte  = rx_d;
                    res_d.rx_last  = (slot_nx == total_q);
                  end
                  slot_d = slot_nx;
                  if (slot_nx >= total_q) begin
                    active_d       = 1'b0;
                    res_d.done_res = 1'b1;
                    lvl_d          = cpol;
                    phase_d        = 1'b0;
                  end else begin
                    tx_d = (slot_nx < SLOT_W'(wlen_q)) ? buf_rd : 8'h00;
                    rx_d = 8'h00;
                  end
                end
              end
            end
          end
        end
        CMD_LOAD: begin
          buf_we = !active_q && (SLOT_W'(in_data_i.load_index) < DEPTH_W);
        end
        CMD_START: begin
          if (active_q || (in_data_i.overlap_count > in_data_i.write_count)
              || (8'(in_data_i.overlap_count) > in_data_i.read_count)
              || (SLOT_W'(in_data_i.write_count) > DEPTH_W)) begin
            res_d.start_error = 1'b1;
          end else begin
            wlen_d  = in_data_i.write_count;
            cap_d   = in_data_i.write_count - in_data_i.overlap_count;
            total_d = start_total;
            if (start_total == '0) begin
              res_d.done_res = 1'b1;
            end else begin
              active_d = 1'b1;
              slot_d   = '0;
              bit_d    = '0;
              div_d    = '0;
              phase_d  = 1'b0;
              lvl_d    = cpol;
              tx_d     = (in_data_i.write_count != 5'd0) ? buf_rd : 8'h00;
              rx_d     = 8'h00;
            end
          end
        end
        default: ;
      endcase
    end

    // Line levels after this item
    res_d.cs_n     = !active_d;
    res_d.sclk     = active_d ? lvl_d : cpol;
    res_d.mosi     = active_d && tx_d[7];
    res_d.busy_res = active_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      total_q  <= '0;
      cap_q    <= '0;
      wlen_q   <= '0;
      bit_q    <= '0;
      div_q    <= '0;
      lvl_q    <= 1'b0;
      phase_q  <= 1'b0;
      tx_q     <= '0;
      rx_q     <= '0;
      active_q <= 1'b0;
    end else begin
      slot_q   <= slot_d;
      total_q  <= total_d;
      cap_q    <= cap_d;
      wlen_q   <= wlen_d;
      bit_q    <= bit_d;
      div_q    <= div_d;
      lvl_q    <= lvl_d;
      phase_q  <= phase_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      active_q <= active_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

>>> tb/sv/spi_master_write_read_transaction_unit_tb.sv
`timescale 1ns / 100ps

module spi_master_write_read_transaction_unit_tb;
  import spimw_pkg::*;

  localparam int unsigned BUF_DEPTH   = 16;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          ITEM_TARGET = 1550;
  localparam int          PHASE_MIN   = 60;
  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_AT     = 700;
  localparam int          HOLD_CYCLES = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  spi_master_write_read_transaction_unit #(
    .WRITE_DEPTH(BUF_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Items waiting to be offered, and results predicted but not yet seen
  in_t  pending_items[$];
  out_t expected_results[$];
  int   pushed_count   = 0;
  int   accepted_count = 0;
  int   mismatches     = 0;
  bit   idle_en        = 1'b1;

  // Shadow of the SPI engine state
  logic [7:0] sh_buf [BUF_DEPTH];
  logic [8:0] sh_slot;
  logic [2:0] sh_bit;
  logic [6:0] sh_div;
  logic       sh_sclk;
  logic       sh_trailing;
  logic [7:0] sh_tx;
  logic [7:0] sh_rx;
  logic       sh_busy;
  logic [4:0] sh_wlen;
  logic [7:0] sh_rlen;
  logic [4:0] sh_olen;
  logic [1:0] sh_mode;
  logic [2:0] sh_baud;

  initial begin
    for (int i = 0; i < BUF_DEPTH; i++) sh_buf[i] = 8'h00;
    sh_slot = '0; sh_bit = '0; sh_div = '0; sh_sclk = 1'b0; sh_trailing = 1'b0;
    sh_tx = '0; sh_rx = '0; sh_busy = 1'b0;
    sh_wlen = '0; sh_rlen = '0; sh_olen = '0; sh_mode = '0; sh_baud = '0;
  end

  // Advance the shadow by one item and return the status it produces
  function automatic out_t spi_predict(in_t it);
    out_t res;
    logic cpol, cpha;
    int   half, total;
    res  = '0;
    cpol = sh_mode[1];
    cpha = sh_mode[0];
    half = 1 << sh_baud;
    case (it.cmd)
      CMD_TICK: begin
        if (sh_busy) begin
          if (int'(sh_div) + 1 < half) begin
            sh_div = sh_div + 7'd1;
          end else begin
            sh_div = '0;
            if (!sh_trailing) begin
              sh_sclk     = ~cpol;
              sh_trailing = 1'b1;
              if (!cpha) sh_rx = {sh_rx[6:0], it.miso};
              else if (sh_bit != 3'd0) sh_tx = sh_tx << 1;
            end else begin
              sh_sclk     = cpol;
              sh_trailing = 1'b0;
              if (!cpha) sh_tx = sh_tx << 1;
              else sh_rx = {sh_rx[6:0], it.miso};
              sh_bit = sh_bit + 3'd1;
              // end of a byte slot
              if (sh_bit == 3'd0) begin
                total = int'(sh_wlen) + int'(sh_rlen) - int'(sh_olen);
                if (int'(sh_slot) + int'(sh_olen) >= int'(sh_wlen)) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = sh_rx;
                  res.rx_last  = (int'(sh_slot) + 1 == total);
                end
                sh_slot = sh_slot + 9'd1;
                if (int'(sh_slot) >= total) begin
                  sh_busy       = 1'b0;
                  res.done_res  = 1'b1;
                  sh_sclk       = cpol;
                  sh_trailing   = 1'b0;
                end else begin
                  sh_tx = (int'(sh_slot) < int'(sh_wlen)) ? sh_buf[sh_slot[3:0]] : 8'h00;
                  sh_rx = '0;
                end
              end
            end
          end
        end
      end
      CMD_LOAD: begin
        if (!sh_busy && it.load_index < BUF_DEPTH) sh_buf[it.load_index] = it.load_byte;
      end
      CMD_START: begin
        if (sh_busy || it.overlap_count > it.write_count ||
            8'(it.overlap_count) > it.read_count || it.write_count > BUF_DEPTH) begin
          res.start_error = 1'b1;
        end else begin
          sh_wlen = it.write_count;
          sh_rlen = it.read_count;
          sh_olen = it.overlap_count;
          if (int'(it.write_count) + int'(it.read_count) - int'(it.overlap_count) == 0) begin
            res.done_res = 1'b1;
          end else begin
            sh_busy     = 1'b1;
            sh_slot     = '0;
            sh_bit      = '0;
            sh_div      = '0;
            sh_trailing = 1'b0;
            sh_sclk     = cpol;
            sh_tx       = (it.write_count > 5'd0) ? sh_buf[0] : 8'h00;
            sh_rx       = '0;
          end
        end
      end
      default: ;
    endcase
    res.cs_n     = ~sh_busy;
    res.sclk     = sh_busy ? sh_sclk : sh_mode[1];
    res.mosi     = sh_busy ? sh_tx[7] : 1'b0;
    res.busy_res = sh_busy;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Gap length: mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sender: offers queued items, holds each until taken
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        send_gap    = idle_en ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while items are queued
  int  recv_gap = 0;
  int  hold_left = 0;
  int  results_taken = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) results_taken++;
      if (!hold_done && results_taken >= HOLD_AT && pending_items.size() > 16) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        recv_gap = pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: register writes, accepted items, result checks
  always @(posedge clk_i) begin : monitor
    out_t exp_res;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && !sh_busy) begin
        if (paddr[2] == REG_CLK_DIV) sh_baud = pwdata[2:0];
        else sh_mode = pwdata[1:0];
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(spi_predict(in_data_i));
        accepted_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("cs_n", 8'(exp_res.cs_n), 8'(out_data_o.cs_n));
          check_field("sclk", 8'(exp_res.sclk), 8'(out_data_o.sclk));
          check_field("mosi", 8'(exp_res.mosi), 8'(out_data_o.mosi));
          check_field("rx_valid", 8'(exp_res.rx_valid), 8'(out_data_o.rx_valid));
          check_field("rx_byte", exp_res.rx_byte, out_data_o.rx_byte);
          check_field("rx_last", 8'(exp_res.rx_last), 8'(out_data_o.rx_last));
          check_field("busy_res", 8'(exp_res.busy_res), 8'(out_data_o.busy_res));
          check_field("done_res", 8'(exp_res.done_res), 8'(out_data_o.done_res));
          check_field("start_error", 8'(exp_res.start_error),
                      8'(out_data_o.start_error));
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic in_t rand_item(input logic [1:0] code);
    in_t it;
    it.cmd           = code;
    it.miso          = 1'($urandom_range(0, 1));
    it.load_index    = 4'($urandom_range(0, 15));
    it.load_byte     = 8'($urandom_range(0, 255));
    it.write_count   = 5'($urandom_range(0, 31));
    it.read_count    = 8'($urandom_range(0, 255));
    it.overlap_count = 5'($urandom_range(0, 31));
    return it;
  endfunction

  task automatic queue_item(input in_t it);
    pending_items.push_back(it);
    pushed_count++;
  endtask

  task automatic queue_start(input int wc, input int rc, input int oc);
    in_t it;
    it = rand_item(CMD_START);
    it.write_count   = 5'(wc);
    it.read_count    = 8'(rc);
    it.overlap_count = 5'(oc);
    queue_item(it);
  endtask

  // Start, then exactly the ticks the transfer needs, with busy-time noise mixed in
  task automatic queue_transfer(input int wc, input int rc, input int oc, input int baud_sel);
    int ticks;
    int kind;
    queue_start(wc, rc, oc);
    ticks = (wc + rc - oc) * 16 * (1 << baud_sel);
    for (int t = 0; t < ticks; t++) begin
      if (t < ticks - 1 && $urandom_range(0, 11) == 0) begin
        kind = $urandom_range(0, 2);
        if (kind == 0) queue_item(rand_item(CMD_START));
        else if (kind == 1) queue_item(rand_item(CMD_LOAD));
        else queue_item(rand_item(CMD_UNUSED));
      end
      queue_item(rand_item(CMD_TICK));
    end
  endtask

  // A start that breaks one of the count rules while idle
  task automatic queue_bad_start();
    in_t it;
    it = rand_item(CMD_START);
    if (it.overlap_count <= it.write_count && 8'(it.overlap_count) <= it.read_count &&
        it.write_count <= BUF_DEPTH)
      it.write_count = 5'd17 + 5'($urandom_range(0, 14));
    queue_item(it);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [2:0] field);
    logic [31:0] word;
    word = $urandom;
    word[2:0] = field;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_count != pushed_count || expected_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // Mode/baud settings walked first; random low-baud settings after
  logic [1:0] mode_plan [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
  logic [2:0] baud_plan [10] = '{3'd0, 3'd0, 3'd1, 3'd0, 3'd5, 3'd2, 3'd4, 3'd0, 3'd1, 3'd3};

  initial begin : stimulus
    in_t        it;
    int         phase_no;
    int         phase_base;
    int         wc, rc, oc, sel;
    logic [1:0] mode;
    logic [2:0] baud;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill the whole buffer, byte extremes at the first two entries
    for (int i = 0; i < BUF_DEPTH; i++) begin
      it = rand_item(CMD_LOAD);
      it.load_index = 4'(i);
      if (i == 0) it.load_byte = 8'h00;
      if (i == 1) it.load_byte = 8'hFF;
      queue_item(it);
    end
    queue_item(rand_item(CMD_TICK));     // tick while idle
    queue_item(rand_item(CMD_UNUSED));   // reserved command
    queue_start(0, 0, 0);                // zero slots
    queue_start(3, 200, 5);              // overlap above write count
    queue_start(10, 2, 4);               // overlap above read count
    queue_start(31, 255, 0);             // write count above depth
    queue_start(17, 1, 0);
    queue_transfer(2, 2, 1, 0);
    wait_drained();

    phase_no = 0;
    while (phase_no < 10 || pushed_count < ITEM_TARGET) begin
      if (phase_no < 10) begin
        mode = mode_plan[phase_no];
        baud = baud_plan[phase_no];
      end else begin
        mode = 2'($urandom_range(0, 3));
        baud = 3'($urandom_range(0, 2));
      end
      idle_en = ($urandom_range(0, 3) != 0);
      cfg_write(REG_SPI_MODE, {1'b0, mode});
      cfg_write(REG_CLK_DIV, baud);
      phase_base = pushed_count;
      do begin
        for (int k = $urandom_range(0, 3); k > 0; k--) queue_item(rand_item(CMD_LOAD));
        if ($urandom_range(0, 3) == 0) queue_bad_start();
        if ($urandom_range(0, 7) == 0) queue_item(rand_item(CMD_TICK));
        if ($urandom_range(0, 9) == 0) queue_item(rand_item(CMD_UNUSED));
        if (baud >= 3'd4) begin
          wc = $urandom_range(0, 1);
          rc = (wc != 0) ? $urandom_range(0, 1) : 1;
          oc = (wc != 0 && rc != 0) ? 1 : 0;
        end else if (baud >= 3'd2) begin
          wc = $urandom_range(0, 1);
          rc = $urandom_range(0, 1);
          oc = $urandom_range(0, (wc < rc) ? wc : rc);
        end else if (baud == 3'd0 && $urandom_range(0, 14) == 0) begin
          sel = $urandom_range(0, 3);
          wc  = (sel == 3) ? 0 : 16;
          rc  = (sel == 0) ? 16 : (sel == 1) ? 0 : (sel == 2) ? 5 : 20;
          oc  = (sel == 0) ? 16 : (sel == 2) ? 3 : 0;
        end else begin
          wc = $urandom_range(0, 4);
          rc = $urandom_range(0, 4);
          oc = $urandom_range(0, (wc < rc) ? wc : rc);
        end
        queue_transfer(wc, rc, oc, int'(baud));
      end while (pushed_count < phase_base + PHASE_MIN);
      wait_drained();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/spimw_pkg.sv
src/spimw_wbuf.sv
src/spi_master_write_read_transaction_unit.sv
tb/sv/spi_master_write_read_transaction_unit_tb.sv
